FILE: src/frcr_pkg.sv
`default_nettype none
package frcr_pkg;

   localparam int MAX_IMAGE_SIDE    = 512;
   localparam int MAX_STRIP_WIDTH   = 32;
   localparam int MAX_PROFILE_RANGE = 64;

   // field widths
   localparam int PIX_W   = 9;
   localparam int VAL_W   = 8;
   localparam int COORD_W = 19;
   localparam int DIR_W   = 16;
   localparam int SIDE_W  = 10;
   localparam int SW_W    = 6;
   localparam int RNG_W   = 7;
   localparam int HW_W    = SW_W - 1;
   localparam int HR_W    = RNG_W - 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIDE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_WIDTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROFILE_RANGE = 2'd3;

   localparam logic [SIDE_W-1:0] RST_IMAGE_WIDTH   = 10'd512;
   localparam logic [SIDE_W-1:0] RST_IMAGE_HEIGHT  = 10'd512;
   localparam logic [SW_W-1:0]   RST_STRIP_WIDTH   = 6'd4;
   localparam logic [RNG_W-1:0]  RST_PROFILE_RANGE = 7'd20;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // derived sizes
   localparam int FRAME_DEPTH = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);
   localparam int PROF_DEPTH  = MAX_PROFILE_RANGE + 1;
   localparam int NSTRIP_W    = $clog2(MAX_STRIP_WIDTH + 1);
   localparam int SUM_W       = $clog2(MAX_PROFILE_RANGE * (MAX_PROFILE_RANGE + 1) / 2 + 1);
   localparam int POS_W       = 28;
   localparam int TERM_W      = POS_W + 2;
   localparam int OFF_W       = 9;
   localparam int ACC_W       = TERM_W + VAL_W + 1 + NSTRIP_W;
   localparam int DEN_W       = $clog2((MAX_STRIP_WIDTH + 1) * 255 + 1);
   localparam int NUM_W       = ACC_W + 1;
   localparam int DIV_D_W     = DEN_W + 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic signed [COORD_W:0] COORD_MAX = 20'sd262143;
   localparam logic [COORD_W:0]        COORD_LIM = 20'd262144;

   typedef struct packed {
      logic is_query;
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
      logic [VAL_W-1:0] pixel_value;
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
   } frcr_item_type;

   typedef struct packed {
      logic [SIDE_W-1:0] image_width;
      logic [SIDE_W-1:0] image_height;
      logic [SW_W-1:0]   strip_width;
      logic [RNG_W-1:0]  profile_range;
   } frcr_cfg_type;

endpackage
`default_nettype wire

FILE: src/frcr_if.sv
`default_nettype none
interface frcr_req_if import frcr_pkg::*;;
   logic valid;
   logic ready;
   logic kind;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;
   logic [VAL_W-1:0] pixel_value;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;
   modport source(output valid, kind, pixel_x, pixel_y, pixel_value, vertex_x, vertex_y,
                  dir_x, dir_y, input ready);
   modport sink(input valid, kind, pixel_x, pixel_y, pixel_value, vertex_x, vertex_y,
                dir_x, dir_y, output ready);
endinterface

interface frcr_rsp_if import frcr_pkg::*;;
   logic valid;
   logic ready;
   logic found;
   logic signed [COORD_W-1:0] center_x;
   logic signed [COORD_W-1:0] center_y;
   logic signed [COORD_W-1:0] left_x;
   logic signed [COORD_W-1:0] left_y;
   logic signed [COORD_W-1:0] peak_x;
   logic signed [COORD_W-1:0] peak_y;
   logic signed [COORD_W-1:0] right_x;
   logic signed [COORD_W-1:0] right_y;
   modport source(output valid, found, center_x, center_y, left_x, left_y, peak_x, peak_y,
                  right_x, right_y, input ready);
   modport sink(input valid, found, center_x, center_y, left_x, left_y, peak_x, peak_y,
                right_x, right_y, output ready);
endinterface
`default_nettype wire

FILE: src/frcr_ram.sv
`default_nettype none
module frcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: src/frcr_front.sv
`default_nettype none
module frcr_front import frcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   frcr_req_if.sink      req,
   output logic          q_valid,
   output frcr_item_type q_item,
   input  logic          q_pop
);
   frcr_item_type item_ff [QUEUE_DEPTH];
   frcr_item_type item_in;
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff;
   logic push;

   assign req.ready = (cnt_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = item_ff[rd_ff];

   always_comb begin
      item_in.is_query    = (req.kind == KIND_QUERY);
      item_in.pixel_x     = req.pixel_x;
      item_in.pixel_y     = req.pixel_y;
      item_in.pixel_value = req.pixel_value;
      item_in.vertex_x    = req.vertex_x;
      item_in.vertex_y    = req.vertex_y;
      item_in.dir_x       = req.dir_x;
      item_in.dir_y       = req.dir_y;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !q_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (q_pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

FILE: src/frcr_div.sv
`default_nettype none
module frcr_div import frcr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [DIV_D_W-1:0] den,
   output logic               done,
   output logic [NUM_W-1:0]   quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]   quo_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W-1:0] den_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;
   logic [DIV_D_W:0]   rem_sh, diff;
   logic               ge;

   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = (rem_sh >= {1'b0, den_ff});
   assign done   = done_ff;
   assign quo    = quo_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: src/frcr_back.sv
`default_nettype none
module frcr_back import frcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  frcr_cfg_type  cfg,
   input  logic          q_valid,
   input  frcr_item_type q_item,
   output logic          q_pop,
   frcr_rsp_if.source    rsp
);
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_QINIT = 5'd1;
   localparam logic [4:0] S_SINIT = 5'd2;
   localparam logic [4:0] S_SAMP  = 5'd3;
   localparam logic [4:0] S_SDRN  = 5'd4;
   localparam logic [4:0] S_SEVAL = 5'd5;
   localparam logic [4:0] S_ADIV  = 5'd6;
   localparam logic [4:0] S_AWAIT = 5'd7;
   localparam logic [4:0] S_LRD   = 5'd8;
   localparam logic [4:0] S_LCHK  = 5'd9;
   localparam logic [4:0] S_RRD   = 5'd10;
   localparam logic [4:0] S_RCHK  = 5'd11;
   localparam logic [4:0] S_ACCA  = 5'd12;
   localparam logic [4:0] S_ACCB  = 5'd13;
   localparam logic [4:0] S_NEXT  = 5'd14;
   localparam logic [4:0] S_FIN   = 5'd15;
   localparam logic [4:0] S_FDIV  = 5'd16;
   localparam logic [4:0] S_FWAIT = 5'd17;
   localparam logic [4:0] S_OUT   = 5'd18;

   localparam logic [1:0] PT_CENTER = 2'd0;
   localparam logic [1:0] PT_LEFT   = 2'd1;
   localparam logic [1:0] PT_PEAK   = 2'd2;
   localparam logic [1:0] PT_RIGHT  = 2'd3;

   localparam int Q_W = POS_W - 13;

   logic [4:0] state_ff, state_in;

   logic signed [COORD_W-1:0] vx_ff, vy_ff;
   logic signed [DIR_W-1:0]   dx_ff, dy_ff;
   logic signed [POS_W-1:0]   sx_ff, sy_ff, posx_ff, posy_ff;
   logic [RNG_W-1:0]          k_ff, k1_ff, a_ff, i_ff;
   logic [NSTRIP_W-1:0]       ws_ff;
   logic                      v1_ff, inb1_ff, zero1_ff;
   logic [VAL_W-1:0]          mx_ff, mn_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic [RNG_W-1:0]          cnt_ff;
   logic signed [OFF_W-1:0]   lb_ff, rb_ff, mo_ff;
   logic [2:0]                j_ff;
   logic signed [TERM_W-1:0]  term_ff;
   logic signed [ACC_W-1:0]   acc_ff [8];
   logic [DEN_W-1:0]          den_ff;
   logic [COORD_W-1:0]        res_ff [8];
   logic                      found_ff, neg_ff;
   logic                      rsp_valid_ff, rsp_found_ff;
   logic [COORD_W-1:0]        rsp_res_ff [8];

   logic [HW_W-1:0] hw;
   logic [HR_W-1:0] hr;
   logic [RNG_W-1:0] rng;
   assign hw  = cfg.strip_width[SW_W-1:1];
   assign hr  = cfg.profile_range[RNG_W-1:1];
   assign rng = cfg.profile_range;

   // sample point rounding and frame address
   logic              negx, negy, inb;
   logic [POS_W-1:0]  magx, magy;
   logic [POS_W:0]    rndx, rndy;
   logic [Q_W-1:0]    qx, qy;
   logic [ADDR_W-1:0] frame_raddr, frame_waddr;
   logic [VAL_W-1:0]  frame_q, prof_q, samp;
   logic              frame_we, pix_inb, out_load;

   assign negx = posx_ff[POS_W-1];
   assign negy = posy_ff[POS_W-1];
   assign magx = negx ? POS_W'(-posx_ff) : POS_W'(posx_ff);
   assign magy = negy ? POS_W'(-posy_ff) : POS_W'(posy_ff);
   assign rndx = {1'b0, magx} + (POS_W + 1)'(8192);
   assign rndy = {1'b0, magy} + (POS_W + 1)'(8192);
   assign qx   = rndx[POS_W:14];
   assign qy   = rndy[POS_W:14];
   assign inb  = (qx == '0 || !negx) && (qx < Q_W'(cfg.image_width)) &&
                 (qy == '0 || !negy) && (qy < Q_W'(cfg.image_height));
   assign frame_raddr = ADDR_W'(ADDR_W'(qy[PIX_W-1:0]) * ADDR_W'(cfg.image_width) +
                                ADDR_W'(qx[PIX_W-1:0]));

   assign pix_inb = (SIDE_W'(q_item.pixel_x) < cfg.image_width) &&
                    (SIDE_W'(q_item.pixel_y) < cfg.image_height);
   assign frame_waddr = ADDR_W'(ADDR_W'(q_item.pixel_y) * ADDR_W'(cfg.image_width) +
                                ADDR_W'(q_item.pixel_x));
   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign frame_we = q_pop && !q_item.is_query && pix_inb;

   frcr_ram #(.WIDTH(VAL_W), .DEPTH(FRAME_DEPTH)) u_frame (
      .clock(clock), .we(frame_we), .waddr(frame_waddr), .wdata(q_item.pixel_value),
      .raddr(frame_raddr), .rdata(frame_q)
   );

   assign samp = (inb1_ff && !zero1_ff) ? frame_q : '0;

   frcr_ram #(.WIDTH(VAL_W), .DEPTH(PROF_DEPTH)) u_prof (
      .clock(clock), .we(v1_ff), .waddr(k1_ff), .wdata(samp),
      .raddr(i_ff), .rdata(prof_q)
   );

   logic [VAL_W:0] thr;
   logic           below;
   assign thr   = {1'b0, mx_ff} + {1'b0, mn_ff};
   assign below = ({prof_q, 1'b0} < thr);

   // shared divider
   logic                    div_start, div_done;
   logic [NUM_W-1:0]        div_num, div_quo;
   logic [DIV_D_W-1:0]      div_den, fden;
   logic signed [ACC_W-1:0] acc_sel;
   logic [ACC_W-1:0]        fmag;

   assign acc_sel   = acc_ff[j_ff];
   assign fmag      = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
   assign fden      = (j_ff[2:1] == PT_CENTER) ? DIV_D_W'({den_ff, 7'b0}) :
                                                 DIV_D_W'({den_ff, 6'b0});
   assign div_start = (state_ff == S_ADIV) || (state_ff == S_FDIV);
   assign div_num   = (state_ff == S_ADIV) ?
                      NUM_W'({sum_ff, 1'b0}) + NUM_W'(cnt_ff) :
                      NUM_W'({fmag, 1'b0}) + NUM_W'(fden);
   assign div_den   = (state_ff == S_ADIV) ? DIV_D_W'({cnt_ff, 1'b0}) :
                                             DIV_D_W'({fden, 1'b0});

   frcr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_quo)
   );

   // saturated quotient
   logic [COORD_W:0]        qsat;
   logic signed [COORD_W:0] qres;
   assign qsat = (div_quo > NUM_W'(COORD_LIM)) ? COORD_LIM : div_quo[COORD_W:0];
   always_comb begin
      qres = neg_ff ? $signed(-qsat) : $signed(qsat);
      if (!neg_ff && qsat[COORD_W-1]) begin
         qres = COORD_MAX;
      end
   end

   // strip term for accumulation
   logic signed [POS_W-1:0]  s_sel;
   logic signed [DIR_W-1:0]  d_sel;
   logic signed [OFF_W-1:0]  off_sel;
   logic signed [TERM_W-1:0] s_t, term_in;
   logic signed [TERM_W+VAL_W:0] prod;

   always_comb begin
      s_sel = j_ff[0] ? sy_ff : sx_ff;
      d_sel = j_ff[0] ? dy_ff : dx_ff;
      s_t   = TERM_W'(s_sel);
      unique case (j_ff[2:1])
         PT_CENTER: begin
            off_sel = lb_ff + rb_ff;
            s_t     = s_t <<< 1;
         end
         PT_LEFT:  off_sel = lb_ff;
         PT_PEAK:  off_sel = mo_ff;
         PT_RIGHT: off_sel = rb_ff;
      endcase
      term_in = s_t + TERM_W'(TERM_W'(d_sel) * TERM_W'(off_sel));
   end
   assign prod = term_ff * $signed({1'b0, mx_ff});

   logic signed [POS_W-1:0] sx_init, sy_init, dxhr, dyhr;
   assign sx_init = (POS_W'(vx_ff) <<< 6) + POS_W'(POS_W'(dy_ff) * POS_W'({1'b0, hw}));
   assign sy_init = (POS_W'(vy_ff) <<< 6) - POS_W'(POS_W'(dx_ff) * POS_W'({1'b0, hw}));
   assign dxhr    = POS_W'(POS_W'(dx_ff) * POS_W'({1'b0, hr}));
   assign dyhr    = POS_W'(POS_W'(dy_ff) * POS_W'({1'b0, hr}));

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (q_valid && q_item.is_query) state_in = S_QINIT;
         S_QINIT: state_in = (cfg.strip_width == '0) ? S_FIN : S_SINIT;
         S_SINIT: state_in = S_SAMP;
         S_SAMP:  if (k_ff == rng) state_in = S_SDRN;
         S_SDRN:  state_in = S_SEVAL;
         S_SEVAL: state_in = (mx_ff == '0) ? S_NEXT : S_ADIV;
         S_ADIV:  state_in = S_AWAIT;
         S_AWAIT: if (div_done) state_in = S_LRD;
         S_LRD:   state_in = S_LCHK;
         S_LCHK:  state_in = (below || i_ff == '0) ? S_RRD : S_LRD;
         S_RRD:   state_in = S_RCHK;
         S_RCHK:  state_in = (below || i_ff == rng) ? S_ACCA : S_RRD;
         S_ACCA:  state_in = S_ACCB;
         S_ACCB:  state_in = (j_ff == 3'd7) ? S_NEXT : S_ACCA;
         S_NEXT:  state_in = (ws_ff == {hw, 1'b0}) ? S_FIN : S_SINIT;
         S_FIN:   state_in = (den_ff == '0) ? S_OUT : S_FDIV;
         S_FDIV:  state_in = S_FWAIT;
         S_FWAIT: if (div_done) state_in = (j_ff == 3'd7) ? S_OUT : S_FDIV;
         S_OUT:   if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= (state_ff == S_SAMP);
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      k1_ff    <= k_ff;
      inb1_ff  <= inb;
      zero1_ff <= (k_ff > {hr, 1'b0});
      if (v1_ff) begin
         if (samp > mx_ff) begin
            mx_ff  <= samp;
            sum_ff <= SUM_W'(k1_ff);
            cnt_ff <= RNG_W'(1);
         end else if (samp == mx_ff) begin
            sum_ff <= sum_ff + SUM_W'(k1_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (samp < mn_ff) begin
            mn_ff <= samp;
         end
      end
      if (out_load) begin
         rsp_found_ff <= found_ff;
         rsp_res_ff   <= res_ff;
      end
      unique case (state_ff)
         S_IDLE: begin
            vx_ff <= q_item.vertex_x;
            vy_ff <= q_item.vertex_y;
            dx_ff <= q_item.dir_x;
            dy_ff <= q_item.dir_y;
         end
         S_QINIT: begin
            sx_ff  <= sx_init;
            sy_ff  <= sy_init;
            ws_ff  <= '0;
            den_ff <= '0;
            for (int n = 0; n < 8; n++) begin
               acc_ff[n] <= '0;
            end
         end
         S_SINIT: begin
            posx_ff <= sx_ff - dxhr;
            posy_ff <= sy_ff - dyhr;
            k_ff    <= '0;
            mx_ff   <= '0;
            mn_ff   <= '1;
            sum_ff  <= '0;
            cnt_ff  <= '0;
         end
         S_SAMP: begin
            k_ff    <= k_ff + 1'b1;
            posx_ff <= posx_ff + POS_W'(dx_ff);
            posy_ff <= posy_ff + POS_W'(dy_ff);
         end
         S_AWAIT: begin
            if (div_done) begin
               a_ff  <= div_quo[RNG_W-1:0];
               i_ff  <= div_quo[RNG_W-1:0];
               mo_ff <= OFF_W'(div_quo[RNG_W-1:0]) - OFF_W'(hr);
            end
         end
         S_LCHK: begin
            if (below) begin
               lb_ff <= OFF_W'(i_ff) + OFF_W'(1) - OFF_W'(hr);
               i_ff  <= a_ff;
            end else if (i_ff == '0) begin
               lb_ff <= mo_ff;
               i_ff  <= a_ff;
            end else begin
               i_ff <= i_ff - 1'b1;
            end
            j_ff <= '0;
         end
         S_RCHK: begin
            if (below) begin
               rb_ff <= OFF_W'(i_ff) - OFF_W'(1) - OFF_W'(hr);
            end else if (i_ff == rng) begin
               rb_ff <= mo_ff;
            end else begin
               i_ff <= i_ff + 1'b1;
            end
         end
         S_ACCA: term_ff <= term_in;
         S_ACCB: begin
            acc_ff[j_ff] <= acc_ff[j_ff] + ACC_W'(prod);
            j_ff         <= j_ff + 1'b1;
            if (j_ff == 3'd7) begin
               den_ff <= den_ff + DEN_W'(mx_ff);
            end
         end
         S_NEXT: begin
            ws_ff <= ws_ff + 1'b1;
            sx_ff <= sx_ff - POS_W'(dy_ff);
            sy_ff <= sy_ff + POS_W'(dx_ff);
         end
         S_FIN: begin
            found_ff <= (den_ff != '0);
            j_ff     <= '0;
            for (int n = 0; n < 4; n++) begin
               res_ff[2*n]   <= vx_ff;
               res_ff[2*n+1] <= vy_ff;
            end
         end
         S_FDIV: neg_ff <= acc_sel[ACC_W-1];
         S_FWAIT: begin
            if (div_done) begin
               res_ff[j_ff] <= qres[COORD_W-1:0];
               j_ff         <= j_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = rsp_found_ff;
   assign rsp.center_x = rsp_res_ff[0];
   assign rsp.center_y = rsp_res_ff[1];
   assign rsp.left_x   = rsp_res_ff[2];
   assign rsp.left_y   = rsp_res_ff[3];
   assign rsp.peak_x   = rsp_res_ff[4];
   assign rsp.peak_y   = rsp_res_ff[5];
   assign rsp.right_x  = rsp_res_ff[6];
   assign rsp.right_y  = rsp_res_ff[7];
endmodule
`default_nettype wire

FILE: src/fwhm_ridge_center_refine_unit.sv
// channel  | port            | dir | content
// request  | req (sink)      | in  | pixel write or vertex query, one beat each
// response | rsp (source)    | out | found flag and four Q10.8 points, one beat per query
// config   | csr_we/index/.. | in  | register write, taken the cycle csr_we is high
//
// Pixel write: written to the frame by the back end as it leaves the two-beat queue.
// Query: walks S = W/2*2+1 strips (none if W is 0); a strip reads R+1 pixels, then, unless
// its peak is 0, runs a 46-step serial divide for the peak position and both half-level
// scans; the eight averages share that divider.
// Synchronous active-high reset; frame contents are not cleared.
// Queue takes beats, until it is full, while a result waits in the output register.
`default_nettype none
module fwhm_ridge_center_refine_unit import frcr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   frcr_req_if.sink              req,
   frcr_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   frcr_cfg_type  cfg_ff;
   logic          q_valid, q_pop;
   frcr_item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= RST_IMAGE_WIDTH;
         cfg_ff.image_height  <= RST_IMAGE_HEIGHT;
         cfg_ff.strip_width   <= RST_STRIP_WIDTH;
         cfg_ff.profile_range <= RST_PROFILE_RANGE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:
               cfg_ff.image_width <= (csr_wdata[SIDE_W-1:0] > SIDE_W'(MAX_IMAGE_SIDE)) ?
                                     SIDE_W'(MAX_IMAGE_SIDE) : csr_wdata[SIDE_W-1:0];
            CSR_IMAGE_HEIGHT:
               cfg_ff.image_height <= (csr_wdata[SIDE_W-1:0] > SIDE_W'(MAX_IMAGE_SIDE)) ?
                                      SIDE_W'(MAX_IMAGE_SIDE) : csr_wdata[SIDE_W-1:0];
            CSR_STRIP_WIDTH:
               cfg_ff.strip_width <= (csr_wdata[SW_W-1:0] > SW_W'(MAX_STRIP_WIDTH)) ?
                                     SW_W'(MAX_STRIP_WIDTH) : csr_wdata[SW_W-1:0];
            CSR_PROFILE_RANGE:
               cfg_ff.profile_range <= (csr_wdata[RNG_W-1:0] > RNG_W'(MAX_PROFILE_RANGE)) ?
                                       RNG_W'(MAX_PROFILE_RANGE) : csr_wdata[RNG_W-1:0];
         endcase
      end
   end

   frcr_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   frcr_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .rsp(rsp)
   );
endmodule
`default_nettype wire

FILE: src/frcr_checker.sv
`default_nettype none
module frcr_checker import frcr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic found,
   input logic [COORD_W-1:0] center_x,
   input logic [COORD_W-1:0] center_y,
   input logic [COORD_W-1:0] left_x,
   input logic [COORD_W-1:0] left_y,
   input logic [COORD_W-1:0] peak_x,
   input logic [COORD_W-1:0] peak_y,
   input logic [COORD_W-1:0] right_x,
   input logic [COORD_W-1:0] right_y
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(center_x) &&
      $stable(center_y) && $stable(right_x))
      else $error("stalled response beat changed");

   a_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> center_x == left_x && center_x == peak_x &&
      center_x == right_x && center_y == left_y && center_y == peak_y &&
      center_y == right_y)
      else $error("echoed vertex differs between points");
endmodule

bind fwhm_ridge_center_refine_unit frcr_checker u_frcr_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .found(rsp.found), .center_x(rsp.center_x), .center_y(rsp.center_y),
   .left_x(rsp.left_x), .left_y(rsp.left_y), .peak_x(rsp.peak_x), .peak_y(rsp.peak_y),
   .right_x(rsp.right_x), .right_y(rsp.right_y)
);
`default_nettype wire

FILE: bench/tb_fwhm_ridge_center_refine_unit.sv
`timescale 1ns / 1ps
module tb_fwhm_ridge_center_refine_unit;
   import frcr_pkg::*;

   typedef struct {
      logic              found;
      logic [COORD_W-1:0] pt[8];
   } ridge_fit_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   frcr_req_if req_if ();
   frcr_rsp_if rsp_if ();

   fwhm_ridge_center_refine_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [VAL_W-1:0] frame_mem [0:FRAME_DEPTH-1];
   int unsigned img_w, img_h, strip_w, prof_rng;

   frcr_item_type pending_beats[$];
   ridge_fit_type fits_due[$];
   bit   holding;
   int   burst_left, gap_left, sender_mode;
   int   rx_mode, hold_left, rx_cnt;
   bit   hold_req;
   int   errors, n_beats, n_fits, n_found;
   string pt_name[8] = '{"center_x", "center_y", "left_x", "left_y",
                         "peak_x", "peak_y", "right_x", "right_y"};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void add_beat(frcr_item_type it);
      pending_beats = {pending_beats, it};
   endfunction

   function automatic longint round_q14(longint v);
      if (v >= 0) return (v + 8192) >>> 14;
      return -((-v + 8192) >>> 14);
   endfunction

   function automatic int frame_pixel(longint px, longint py);
      if (px < 0 || py < 0 || px >= img_w || py >= img_h) return 0;
      return frame_mem[py * img_w + px];
   endfunction

   function automatic logic [COORD_W-1:0] avg_coord(longint num, longint den);
      longint mag, q, r;
      mag = num < 0 ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (q > 262144) q = 262144;
      r = num < 0 ? -q : q;
      if (r > 262143) r = 262143;
      if (r < -262144) r = -262144;
      return r[COORD_W-1:0];
   endfunction

   function automatic void predict_ridge(frcr_item_type it);
      int prof[0:MAX_PROFILE_RANGE];
      longint vx, vy, dx, dy, hw, hr, sx, sy, a, mo, lb, rb, den;
      longint acc[8];
      int mx, mn, cnt, sum, thr;
      ridge_fit_type f;
      if (it.is_query == KIND_PIXEL) begin
         if (it.pixel_x < img_w && it.pixel_y < img_h)
            frame_mem[it.pixel_y * img_w + it.pixel_x] = it.pixel_value;
         return;
      end
      vx = it.vertex_x;
      vy = it.vertex_y;
      dx = it.dir_x;
      dy = it.dir_y;
      hw = strip_w / 2;
      hr = prof_rng / 2;
      den = 0;
      foreach (acc[j]) acc[j] = 0;
      for (longint w = -hw; strip_w != 0 && w <= hw; w++) begin
         sx = vx * 64 - dy * w;
         sy = vy * 64 + dx * w;
         mx = 0; mn = 255; cnt = 0; sum = 0;
         foreach (prof[k]) prof[k] = 0;
         for (int k = 0; k <= 2 * hr; k++)
            prof[k] = frame_pixel(round_q14(sx + dx * (k - hr)), round_q14(sy + dy * (k - hr)));
         for (int k = 0; k <= prof_rng; k++) begin
            if (prof[k] > mx) mx = prof[k];
            if (prof[k] < mn) mn = prof[k];
         end
         if (mx == 0) continue;
         for (int k = 0; k <= prof_rng; k++)
            if (prof[k] == mx) begin
               sum += k;
               cnt++;
            end
         a = (2 * sum + cnt) / (2 * cnt);
         mo = a - hr;
         thr = mx + mn;
         lb = mo;
         rb = mo;
         for (longint i = a; i >= 0; i--)
            if (2 * prof[i] < thr) begin
               lb = i + 1 - hr;
               break;
            end
         for (longint i = a; i <= prof_rng; i++)
            if (2 * prof[i] < thr) begin
               rb = i - 1 - hr;
               break;
            end
         acc[0] += (2 * sx + dx * (lb + rb)) * mx;
         acc[1] += (2 * sy + dy * (lb + rb)) * mx;
         acc[2] += (sx + dx * lb) * mx;
         acc[3] += (sy + dy * lb) * mx;
         acc[4] += (sx + dx * mo) * mx;
         acc[5] += (sy + dy * mo) * mx;
         acc[6] += (sx + dx * rb) * mx;
         acc[7] += (sy + dy * rb) * mx;
         den += mx;
      end
      if (den == 0) begin
         f.found = 1'b0;
         for (int j = 0; j < 4; j++) begin
            f.pt[2 * j]     = it.vertex_x;
            f.pt[2 * j + 1] = it.vertex_y;
         end
      end else begin
         f.found = 1'b1;
         f.pt[0] = avg_coord(acc[0], den * 128);
         f.pt[1] = avg_coord(acc[1], den * 128);
         for (int j = 2; j < 8; j++) f.pt[j] = avg_coord(acc[j], den * 64);
      end
      fits_due = {fits_due, f};
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!holding) begin
         if (pending_beats.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid       <= 1'b1;
            req_if.kind        <= pending_beats[0].is_query;
            req_if.pixel_x     <= pending_beats[0].pixel_x;
            req_if.pixel_y     <= pending_beats[0].pixel_y;
            req_if.pixel_value <= pending_beats[0].pixel_value;
            req_if.vertex_x    <= pending_beats[0].vertex_x;
            req_if.vertex_y    <= pending_beats[0].vertex_y;
            req_if.dir_x       <= pending_beats[0].dir_x;
            req_if.dir_y       <= pending_beats[0].dir_y;
            holding = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = sender_mode == 0 ? 0 : ($urandom_range(0, 2) == 0 ? 0 :
                                                   $urandom_range(1, 9));
            end
         end
      end
   end

   // response ready
   always @(negedge clock) begin
      rx_cnt++;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = 3000;
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= $urandom_range(0, 9) < 7;
            default: rsp_if.ready <= (rx_cnt % 7) > 2;
         endcase
      end
   end

   // acceptance, prediction and checking
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   img_w = csr_wdata > MAX_IMAGE_SIDE ? MAX_IMAGE_SIDE : csr_wdata;
               CSR_IMAGE_HEIGHT:  img_h = csr_wdata > MAX_IMAGE_SIDE ? MAX_IMAGE_SIDE : csr_wdata;
               CSR_STRIP_WIDTH:   strip_w = csr_wdata[SW_W-1:0] > MAX_STRIP_WIDTH ?
                                            MAX_STRIP_WIDTH : csr_wdata[SW_W-1:0];
               CSR_PROFILE_RANGE: prof_rng = csr_wdata[RNG_W-1:0] > MAX_PROFILE_RANGE ?
                                             MAX_PROFILE_RANGE : csr_wdata[RNG_W-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            predict_ridge(pending_beats.pop_front());
            holding = 1'b0;
            n_beats++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            ridge_fit_type e;
            logic [COORD_W-1:0] got[8];
            got = '{rsp_if.center_x, rsp_if.center_y, rsp_if.left_x, rsp_if.left_y,
                    rsp_if.peak_x, rsp_if.peak_y, rsp_if.right_x, rsp_if.right_y};
            n_fits++;
            if (rsp_if.found) n_found++;
            if (fits_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat", $time);
            end else begin
               e = fits_due.pop_front();
               if (rsp_if.found !== e.found) begin
                  errors++;
                  $display("%0t: found expected %0d actual %0d", $time, e.found, rsp_if.found);
               end
               for (int j = 0; j < 8; j++)
                  if (got[j] !== e.pt[j]) begin
                     errors++;
                     $display("%0t: %s expected %0d actual %0d", $time, pt_name[j],
                              $signed(e.pt[j]), $signed(got[j]));
                  end
            end
         end
      end
   end

   function automatic frcr_item_type pixel_beat(int x, int y, int v);
      frcr_item_type it;
      it = frcr_item_type'({$urandom, $urandom, $urandom, $urandom});
      it.is_query    = KIND_PIXEL;
      it.pixel_x     = PIX_W'(x);
      it.pixel_y     = PIX_W'(y);
      it.pixel_value = VAL_W'(v);
      return it;
   endfunction

   function automatic frcr_item_type query_beat(int vx, int vy, int dx, int dy);
      frcr_item_type it;
      it = frcr_item_type'({$urandom, $urandom, $urandom, $urandom});
      it.is_query = KIND_QUERY;
      it.vertex_x = COORD_W'(vx);
      it.vertex_y = COORD_W'(vy);
      it.dir_x    = DIR_W'(dx);
      it.dir_y    = DIR_W'(dy);
      return it;
   endfunction

   function automatic frcr_item_type rand_query(int w, int h);
      real ang;
      if ($urandom_range(0, 9) == 0)
         return query_beat($urandom, $urandom, $urandom, $urandom);
      ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
      return query_beat($urandom_range(0, (w + 2) * 256) - 256,
                        $urandom_range(0, (h + 2) * 256) - 256,
                        int'(16384.0 * $cos(ang)), int'(16384.0 * $sin(ang)));
   endfunction

   task automatic wait_drained();
      while (pending_beats.size() != 0 || holding || fits_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(val);
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // style: 0 random, 1 vertical ridge, 2 constant, 3 sparse, 4 random in columns 200..320
   task automatic run_phase(int w_raw, int h_raw, int sw, int rng, int style, int n_rand,
                            int rxm);
      int w, h, v;
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, w_raw);
      write_csr(CSR_IMAGE_HEIGHT, h_raw);
      write_csr(CSR_STRIP_WIDTH, sw);
      write_csr(CSR_PROFILE_RANGE, rng);
      w = w_raw > MAX_IMAGE_SIDE ? MAX_IMAGE_SIDE : w_raw;
      h = h_raw > MAX_IMAGE_SIDE ? MAX_IMAGE_SIDE : h_raw;
      rx_mode = rxm;
      sender_mode = $urandom_range(0, 2);
      @(posedge clock);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            if (style == 4 && (x < 200 || x > 320)) continue;
            case (style)
               0, 4: v = $urandom_range(0, 255);
               1: v = (x - w / 2) * (x - w / 2) <= 1 ? 255 :
                      ((x - w / 2) * (x - w / 2) < 9 ? 90 + $urandom_range(0, 40) : 0);
               2: v = 200;
               default: v = $urandom_range(0, 5) == 0 ? $urandom_range(1, 255) : 0;
            endcase
            add_beat(pixel_beat(x, y, v));
         end
      for (int i = 0; i < n_rand; i++) begin
         case ($urandom_range(0, 19))
            0, 1: add_beat(pixel_beat($urandom_range(0, 511),
                                      $urandom_range(0, 511), $urandom));
            2: if (w > 0 && h > 0)
                  add_beat(pixel_beat($urandom_range(0, w - 1),
                                      $urandom_range(0, h - 1), $urandom));
            default: add_beat(rand_query(w, h));
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = KIND_PIXEL;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      req_if.pixel_value = '0;
      req_if.vertex_x = '0;
      req_if.vertex_y = '0;
      req_if.dir_x = '0;
      req_if.dir_y = '0;
      rsp_if.ready = 1'b0;
      holding = 1'b0;
      hold_req = 1'b0;
      burst_left = 1;
      gap_left = 0;
      img_w = RST_IMAGE_WIDTH;
      img_h = RST_IMAGE_HEIGHT;
      strip_w = RST_STRIP_WIDTH;
      prof_rng = RST_PROFILE_RANGE;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: ridge across a 16x16 frame
      run_phase(16, 16, 4, 20, 1, 0, 0);
      add_beat(query_beat(8 * 256, 8 * 256, 16384, 0));
      add_beat(query_beat(7 * 256 + 77, 5 * 256, 16384, 0));
      add_beat(query_beat(8 * 256, 8 * 256, -16384, 0));
      add_beat(query_beat(8 * 256, 8 * 256, 0, 16384));
      add_beat(query_beat(8 * 256, 8 * 256, 0, -16384));
      add_beat(query_beat(8 * 256, 8 * 256, 11585, 11585));
      add_beat(query_beat(262143, 262143, 16384, 0));
      add_beat(query_beat(-262144, -262144, -16384, 16384));
      add_beat(query_beat(0, 0, -32768, 32767));
      add_beat(query_beat(-128, 4000, 16384, 0));
      // flat frame, no drop on either side
      run_phase(8, 8, 2, 2, 2, 0, 1);
      add_beat(query_beat(4 * 256, 4 * 256, 16384, 0));
      add_beat(query_beat(4 * 256, 4 * 256, 0, -16384));
      // zero strip width echoes the vertex
      run_phase(1, 1, 0, 0, 0, 0, 0);
      add_beat(query_beat(0, 0, 16384, 0));
      add_beat(query_beat(-5, 77, 0, 16384));
      // one strip, odd profile range
      run_phase(1, 1, 1, 1, 2, 0, 2);
      add_beat(query_beat(0, 0, 16384, 0));
      add_beat(query_beat(0, 0, -16384, 0));
      // zero width: every pixel outside
      run_phase(0, 1023, 6, 9, 0, 0, 1);
      add_beat(query_beat(256, 256, 0, 16384));
      add_beat(pixel_beat(0, 0, 255));
      // oversized registers, largest strip and profile
      run_phase(1023, 1, 63, 127, 4, 0, 0);
      add_beat(query_beat(256 * 256, 0, 16384, 0));
      add_beat(query_beat(260 * 256 + 128, 128, 16384, 0));
      add_beat(query_beat(260 * 256, 0, 11585, -11585));

      // random phases; response ready held low for a long stretch in one of them
      for (int p = 0; p < 8; p++) begin
         run_phase($urandom_range(3, 6), $urandom_range(3, 6), $urandom_range(0, 9),
                   $urandom_range(0, 24), p % 4, 12, p % 3);
         if (p == 2) hold_req = 1'b1;
      end
      run_phase(8, 8, 32, 64, 1, 4, 1);

      wait_drained();
      repeat (50) @(posedge clock);
      $display("ran %0d request beats, checked %0d results (%0d with a ridge found)",
               n_beats, n_fits, n_found);
      $display("covered register extremes, zero strip, odd profile, flat and sparse frames");
      if (errors == 0 && fits_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

endmodule
